>>> rtl/core/pfx_eval_pkg.sv
// ----------------------------------------------------------------------------
// pfx_eval_pkg
// Shared codes, request types and controller/datapath links for the postfix
// expression evaluator.
// ----------------------------------------------------------------------------
package pfx_eval_pkg;

	// Default sizing
	localparam int STACK_DEPTH_DEF = 128;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int FRAC_BITS       = 16;

	// Fixed request field widths
	localparam int KIND_W    = 2;
	localparam int OPERAND_W = 32;
	localparam int OPCODE_W  = 2;
	localparam int STATUS_W  = 3;
	localparam int FINAL_W   = 32;
	localparam int DEPTH_W   = 8;

	// Token kinds
	localparam logic [KIND_W-1:0] KIND_NUM = 2'd0;
	localparam logic [KIND_W-1:0] KIND_OP  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END = 2'd2;

	// Operators
	localparam logic [OPCODE_W-1:0] OP_ADD = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_SUB = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_MUL = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_DIV = 2'd3;

	// Status / sticky error codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLW = 3'd2;
	localparam logic [STATUS_W-1:0] ST_LEFTOVER = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 3'd4;

	typedef struct packed {
		logic        [KIND_W-1:0]    kind;
		logic signed [OPERAND_W-1:0] operand_value;
		logic        [OPCODE_W-1:0]  operator_code;
	} pfx_in_t;

	typedef struct packed {
		logic        [STATUS_W-1:0] status;
		logic signed [FINAL_W-1:0]  final_value;
		logic                       is_final;
		logic        [DEPTH_W-1:0]  depth_now;
	} pfx_out_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic load_addsub;
		logic mul_start;
		logic div_start;
		logic mul_step;
		logic div_step;
		logic fix_mul;
		logic fix_div;
		logic commit;
	} pfx_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [OPCODE_W-1:0] operator_code;
		logic                err_held;
		logic                cnt_lt2;
		logic                divisor_zero;
	} pfx_stat_t;

endpackage

>>> rtl/core/pfx_eval_dp.sv
// ----------------------------------------------------------------------------
// pfx_eval_dp
// Operand stack, top-of-stack register, serial multiplier and divider,
// saturation and result register.
// ----------------------------------------------------------------------------
module pfx_eval_dp import pfx_eval_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  pfx_in_t   in_data,
	input  pfx_cmd_t  cmd,
	output pfx_stat_t stat,
	output pfx_out_t  out_data
);

	localparam int VW     = VALUE_WIDTH;
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int QUO_W  = VW + FRAC_BITS;
	localparam int MAG_W  = 2 * VW;
	localparam int XW     = (VW > OPERAND_W) ? VW : OPERAND_W;

	localparam logic signed [VW:0]   AS_MAX  = {2'b00, {(VW-1){1'b1}}};
	localparam logic signed [VW:0]   AS_MIN  = {2'b11, {(VW-1){1'b0}}};
	localparam logic [MAG_W-1:0]     LIM_POS = {{(VW+1){1'b0}}, {(VW-1){1'b1}}};
	localparam logic [MAG_W-1:0]     LIM_NEG = {{VW{1'b0}}, 1'b1, {(VW-1){1'b0}}};
	localparam logic signed [XW-1:0] VMAX_X  = {{(XW-VW+1){1'b0}}, {(VW-1){1'b1}}};
	localparam logic signed [XW-1:0] VMIN_X  = {{(XW-VW+1){1'b1}}, {(VW-1){1'b0}}};
	localparam logic signed [XW-1:0] FMAX_X  = {{(XW-FINAL_W+1){1'b0}}, {(FINAL_W-1){1'b1}}};
	localparam logic signed [XW-1:0] FMIN_X  = {{(XW-FINAL_W+1){1'b1}}, {(FINAL_W-1){1'b0}}};

	logic signed [VW-1:0] stack_mem [STACK_DEPTH];

	pfx_in_t              item_q;
	pfx_out_t             out_q;
	logic [CNT_W-1:0]     count_q;
	logic [STATUS_W-1:0]  err_q;
	logic signed [VW-1:0] tos_q;
	logic signed [VW-1:0] second_q;
	logic signed [VW-1:0] res_q;
	logic                 neg_q;
	logic [VW-1:0]        mcand_q;
	logic [VW-1:0]        mhi_q;
	logic [VW-1:0]        mlo_q;
	logic [VW-1:0]        dvsr_q;
	logic [VW-1:0]        rem_q;
	logic [QUO_W-1:0]     nq_q;

	logic signed [VW:0]   as_l, as_r, as_sum, as_clamp;
	logic [VW-1:0]        l_mag, r_mag;
	logic [VW:0]          mul_sum;
	logic [VW:0]          div_t, div_diff;
	logic                 div_ge;
	logic [MAG_W-1:0]     mag_mul, fix_mag, fix_lim, fix_clamp;
	logic [VW-1:0]        fix_low, fix_res;
	logic signed [XW-1:0] push_x, push_clamp, tos_x, tos_clamp;

	logic [CNT_W-1:0]     nxt_count;
	logic [STATUS_W-1:0]  nxt_err;
	logic [STATUS_W-1:0]  rsp_status;
	logic signed [VW-1:0] nxt_tos;
	logic signed [FINAL_W-1:0] rsp_final;
	logic                 rsp_is_final;
	logic                 mem_we;
	logic [ADDR_W-1:0]    rd_addr, wr_addr;

	assign stat.kind          = item_q.kind;
	assign stat.operator_code = item_q.operator_code;
	assign stat.err_held      = (err_q != ST_OK);
	assign stat.cnt_lt2       = (count_q < CNT_W'(2));
	assign stat.divisor_zero  = (tos_q == '0);
	assign out_data           = out_q;

	assign rd_addr = ADDR_W'(count_q - CNT_W'(2));
	assign wr_addr = ADDR_W'(count_q - CNT_W'(1));

	// Add / subtract with saturation
	always_comb begin
		as_l   = (VW+1)'(second_q);
		as_r   = (VW+1)'(tos_q);
		as_sum = (item_q.operator_code == OP_SUB) ? (as_l - as_r) : (as_l + as_r);
		if (as_sum > AS_MAX) begin
			as_clamp = AS_MAX;
		end else if (as_sum < AS_MIN) begin
			as_clamp = AS_MIN;
		end else begin
			as_clamp = as_sum;
		end
	end

	assign l_mag = second_q[VW-1] ? (~second_q + 1'b1) : second_q;
	assign r_mag = tos_q[VW-1] ? (~tos_q + 1'b1) : tos_q;

	// One shift-add step and one restoring-divide step
	assign mul_sum  = {1'b0, mhi_q} + (mlo_q[0] ? {1'b0, mcand_q} : '0);
	assign div_t    = {rem_q, nq_q[QUO_W-1]};
	assign div_ge   = (div_t >= {1'b0, dvsr_q});
	assign div_diff = div_t - {1'b0, dvsr_q};

	// Product without its fraction bits, or the quotient: clamp the magnitude, apply the sign
	assign mag_mul   = {mhi_q, mlo_q} >> FRAC_BITS;
	assign fix_mag   = cmd.fix_mul ? mag_mul : MAG_W'(nq_q);
	assign fix_lim   = neg_q ? LIM_NEG : LIM_POS;
	assign fix_clamp = (fix_mag > fix_lim) ? fix_lim : fix_mag;
	assign fix_low   = fix_clamp[VW-1:0];
	assign fix_res   = neg_q ? (~fix_low + 1'b1) : fix_low;

	// Clamp an incoming number to the value range, and the top to the result width
	always_comb begin
		push_x = XW'(item_q.operand_value);
		tos_x  = XW'(tos_q);
		if (push_x > VMAX_X) begin
			push_clamp = VMAX_X;
		end else if (push_x < VMIN_X) begin
			push_clamp = VMIN_X;
		end else begin
			push_clamp = push_x;
		end
		if (tos_x > FMAX_X) begin
			tos_clamp = FMAX_X;
		end else if (tos_x < FMIN_X) begin
			tos_clamp = FMIN_X;
		end else begin
			tos_clamp = tos_x;
		end
	end

	// Next stack state and response for the held request
	always_comb begin
		nxt_count    = count_q;
		nxt_err      = err_q;
		nxt_tos      = tos_q;
		mem_we       = 1'b0;
		rsp_final    = '0;
		rsp_is_final = 1'b0;
		case (item_q.kind)
			KIND_END: begin
				rsp_is_final = 1'b1;
				nxt_count    = '0;
				nxt_err      = ST_OK;
			end
			KIND_NUM: begin
				if (err_q == ST_OK) begin
					if (count_q == CNT_W'(STACK_DEPTH)) begin
						nxt_err = ST_OVERFLOW;
					end else begin
						mem_we    = (count_q != '0);
						nxt_tos   = push_clamp[VW-1:0];
						nxt_count = count_q + CNT_W'(1);
					end
				end
			end
			KIND_OP: begin
				if (err_q == ST_OK) begin
					if (count_q < CNT_W'(2)) begin
						nxt_err = ST_UNDERFLW;
					end else if (item_q.operator_code == OP_DIV && tos_q == '0) begin
						nxt_err = ST_DIV_ZERO;
					end else begin
						nxt_count = count_q - CNT_W'(1);
						nxt_tos   = res_q;
					end
				end
			end
			default: begin
			end
		endcase
		rsp_status = nxt_err;
		if (item_q.kind == KIND_END) begin
			if (err_q != ST_OK) begin
				rsp_status = err_q;
			end else if (count_q != CNT_W'(1)) begin
				rsp_status = ST_LEFTOVER;
			end else begin
				rsp_status = ST_OK;
				rsp_final  = tos_clamp[FINAL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q   <= ST_OK;
		end else if (cmd.commit) begin
			count_q <= nxt_count;
			err_q   <= nxt_err;
		end
	end

	// Stack memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.commit && mem_we) begin
			stack_mem[wr_addr] <= tos_q;
		end
		if (cmd.accept) begin
			second_q <= stack_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= in_data;
		end
		if (cmd.load_addsub) begin
			res_q <= as_clamp[VW-1:0];
		end
		if (cmd.fix_mul || cmd.fix_div) begin
			res_q <= fix_res;
		end
		if (cmd.mul_start) begin
			mcand_q <= l_mag;
			mhi_q   <= '0;
			mlo_q   <= r_mag;
			neg_q   <= second_q[VW-1] ^ tos_q[VW-1];
		end
		if (cmd.mul_step) begin
			mhi_q <= mul_sum[VW:1];
			mlo_q <= {mul_sum[0], mlo_q[VW-1:1]};
		end
		if (cmd.div_start) begin
			dvsr_q <= r_mag;
			rem_q  <= '0;
			nq_q   <= {l_mag, {FRAC_BITS{1'b0}}};
			neg_q  <= second_q[VW-1] ^ tos_q[VW-1];
		end
		if (cmd.div_step) begin
			rem_q <= div_ge ? div_diff[VW-1:0] : div_t[VW-1:0];
			nq_q  <= {nq_q[QUO_W-2:0], div_ge};
		end
		if (cmd.commit) begin
			tos_q             <= nxt_tos;
			out_q.status      <= rsp_status;
			out_q.final_value <= rsp_final;
			out_q.is_final    <= rsp_is_final;
			out_q.depth_now   <= DEPTH_W'(nxt_count);
		end
	end

endmodule

>>> rtl/core/pfx_eval_ctrl.sv
// ----------------------------------------------------------------------------
// pfx_eval_ctrl
// Sequencer: request intake, operator dispatch, iteration count for the
// serial multiply and divide, and the result handshake.
// ----------------------------------------------------------------------------
module pfx_eval_ctrl import pfx_eval_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  pfx_stat_t stat,
	output pfx_cmd_t  cmd
);

	localparam int ITER_W = $clog2(VALUE_WIDTH + FRAC_BITS);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_EXEC    = 3'd1;
	localparam logic [2:0] S_MUL     = 3'd2;
	localparam logic [2:0] S_DIV     = 3'd3;
	localparam logic [2:0] S_FIX_MUL = 3'd4;
	localparam logic [2:0] S_FIX_DIV = 3'd5;
	localparam logic [2:0] S_COMMIT  = 3'd6;

	logic [2:0]        state_q, state_d;
	logic [ITER_W-1:0] iter_q, iter_d;
	logic              out_valid_q;
	logic              arith;

	assign arith     = (stat.kind == KIND_OP) && !stat.err_held && !stat.cnt_lt2;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		iter_d  = iter_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_COMMIT;
				if (arith) begin
					case (stat.operator_code) inside
						OP_ADD, OP_SUB: begin
							cmd.load_addsub = 1'b1;
						end
						OP_MUL: begin
							cmd.mul_start = 1'b1;
							iter_d        = ITER_W'(VALUE_WIDTH - 1);
							state_d       = S_MUL;
						end
						default: begin
							// a zero divisor is flagged at commit
							if (!stat.divisor_zero) begin
								cmd.div_start = 1'b1;
								iter_d        = ITER_W'(VALUE_WIDTH + FRAC_BITS - 1);
								state_d       = S_DIV;
							end
						end
					endcase
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				iter_d       = iter_q - ITER_W'(1);
				if (iter_q == '0) begin
					state_d = S_FIX_MUL;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				iter_d       = iter_q - ITER_W'(1);
				if (iter_q == '0) begin
					state_d = S_FIX_DIV;
				end
			end
			S_FIX_MUL: begin
				cmd.fix_mul = 1'b1;
				state_d     = S_COMMIT;
			end
			S_FIX_DIV: begin
				cmd.fix_div = 1'b1;
				state_d     = S_COMMIT;
			end
			S_COMMIT: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			iter_q  <= iter_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/postfix_expression_evaluator_unit.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit
// Number, end, add and subtract need no loop; multiply and divide run serial
// loops, one bit a cycle.
// Requests are handled one at a time; the next is taken while a result waits.
// Reset (arst_n low): stack empty, error cleared, no result pending.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_unit import pfx_eval_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pfx_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output pfx_out_t out_data
);

	// Organisation:
	//   - The top of the stack lives in a register; the rest sits in a
	//     single-port-write memory read at one address. An operator request
	//     reads the entry below the top as it is accepted, so both operands
	//     are ready in the cycle after.
	//   - Add and subtract finish in one step with saturation. Multiply runs
	//     a shift-add loop on the operand magnitudes; divide runs a restoring
	//     loop on the magnitude of the left operand shifted up by the fraction
	//     bits. A final step applies the sign and saturates.
	//   - All stack, count and error updates are made in the commit step,
	//     together with loading the result register, so a stalled output
	//     simply holds the sequencer in commit.
	//   - Errors are sticky: requests other than end are dropped while one is
	//     held; the end request reports it, empties the stack and clears it.

	pfx_cmd_t  cmd;
	pfx_stat_t stat;

	pfx_eval_ctrl #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pfx_eval_dp #(
		.STACK_DEPTH(STACK_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (in_data),
		.cmd     (cmd),
		.stat    (stat),
		.out_data(out_data)
	);

endmodule

>>> verif/tb_postfix_expression_evaluator_unit.sv
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator_unit
// Drives postfix token streams into the evaluator and checks every result
// against an in-bench model of the operand stack and its sticky error code.
// Directed cases cover saturation, division by zero, underflow, leftover data
// and ignored tokens, and a fill pass pushes one number too many to reach
// overflow. Random expressions follow, mostly well formed with a share of
// broken streams. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator_unit;
	import pfx_eval_pkg::*;

	// Kind code that the block must ignore
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	localparam int TOKEN_TARGET = 550;
	localparam int STALL_LIMIT  = 3000;
	localparam int TAIL_CYCLES  = VALUE_WIDTH_DEF + 32;

	// Operand stack model with sticky error and a queue of awaited answers
	class rpn_checker;
		logic signed [OPERAND_W-1:0] operand_stack [STACK_DEPTH_DEF];
		int unsigned                 stack_fill;
		logic [STATUS_W-1:0]         held_error;
		pfx_out_t                    awaited [$];
		int unsigned                 fail_count;

		function new();
			stack_fill = 0;
			held_error = ST_OK;
			fail_count = 0;
		endfunction

		function longint unsigned mag_of(longint v);
			return (v < 0) ? longint'(-v) : longint'(v);
		endfunction

		// Saturate a signed magnitude to the Q16.16 range
		function logic signed [OPERAND_W-1:0] fit_q(bit neg, longint unsigned mag);
			longint unsigned cap;
			longint unsigned bits;
			cap = neg ? 64'd2147483648 : 64'd2147483647;
			if (mag > cap)
				mag = cap;
			bits = neg ? (64'd0 - mag) : mag;
			return bits[OPERAND_W-1:0];
		endfunction

		function pfx_out_t evaluate_token(pfx_in_t req);
			pfx_out_t                    ans;
			longint                      lhs;
			longint                      rhs;
			bit                          neg;
			logic signed [OPERAND_W-1:0] res;
			ans = '0;
			if (req.kind == KIND_END) begin
				ans.is_final = 1'b1;
				if (held_error != ST_OK)
					ans.status = held_error;
				else if (stack_fill != 1)
					ans.status = ST_LEFTOVER;
				else begin
					ans.status      = ST_OK;
					ans.final_value = operand_stack[0];
				end
				stack_fill = 0;
				held_error = ST_OK;
			end else begin
				if (held_error == ST_OK && req.kind == KIND_NUM) begin
					if (stack_fill >= STACK_DEPTH_DEF)
						held_error = ST_OVERFLOW;
					else begin
						operand_stack[stack_fill] = req.operand_value;
						stack_fill++;
					end
				end else if (held_error == ST_OK && req.kind == KIND_OP) begin
					if (stack_fill < 2)
						held_error = ST_UNDERFLW;
					else begin
						rhs = operand_stack[stack_fill - 1];
						lhs = operand_stack[stack_fill - 2];
						neg = (lhs < 0) != (rhs < 0);
						if (req.operator_code == OP_DIV && rhs == 0)
							held_error = ST_DIV_ZERO;
						else begin
							if (req.operator_code == OP_ADD)
								res = fit_q(lhs + rhs < 0, mag_of(lhs + rhs));
							else if (req.operator_code == OP_SUB)
								res = fit_q(lhs - rhs < 0, mag_of(lhs - rhs));
							else if (req.operator_code == OP_MUL)
								res = fit_q(neg, (mag_of(lhs) * mag_of(rhs)) >> FRAC_BITS);
							else
								res = fit_q(neg, (mag_of(lhs) << FRAC_BITS) / mag_of(rhs));
							stack_fill--;
							operand_stack[stack_fill - 1] = res;
						end
					end
				end
				ans.status = held_error;
			end
			ans.depth_now = stack_fill[DEPTH_W-1:0];
			return ans;
		endfunction

		// Returns 1 when the token does real work rather than being ignored
		function int note_token(pfx_in_t req);
			int acted;
			acted = (req.kind == KIND_SPARE ||
			         (held_error != ST_OK && req.kind != KIND_END)) ? 0 : 1;
			awaited.push_back(evaluate_token(req));
			return acted;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
			fail_count++;
		endtask

		task check_answer(pfx_out_t got);
			pfx_out_t want;
			if (awaited.size() == 0) begin
				flag_mismatch("unrequested result", got.final_value, 32'd0);
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status)
				flag_mismatch("status", got.status, want.status);
			if (got.final_value !== want.final_value)
				flag_mismatch("final_value", got.final_value, want.final_value);
			if (got.is_final !== want.is_final)
				flag_mismatch("is_final", got.is_final, want.is_final);
			if (got.depth_now !== want.depth_now)
				flag_mismatch("depth_now", got.depth_now, want.depth_now);
		endtask
	endclass

	logic     clk       = 1'b0;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	pfx_in_t  in_data;
	logic     out_valid;
	logic     out_ready = 1'b0;
	pfx_out_t out_data;

	rpn_checker sb;
	bit         no_idle;
	int         rx_hold     = 0;
	int         tokens_done = 0;

	postfix_expression_evaluator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Idle length: mostly short, now and then long
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Operand mix: zero, range limits, small Q16.16 values, raw noise
	function automatic logic [OPERAND_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 16) begin
			case ($urandom_range(0, 3))
				0:       return 32'h7FFF_FFFF;
				1:       return 32'h8000_0000;
				2:       return 32'hFFFF_FFFF;
				default: return 32'h0000_0001;
			endcase
		end
		if (r < 60)
			return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
		return $urandom();
	endfunction

	function automatic logic [OPCODE_W-1:0] pick_opcode();
		return OPCODE_W'($urandom_range(0, 3));
	endfunction

	function automatic pfx_in_t make_token(logic [KIND_W-1:0] k, logic [OPERAND_W-1:0] v,
	                                       logic [OPCODE_W-1:0] o);
		pfx_in_t t;
		t.kind          = k;
		t.operand_value = v;
		t.operator_code = o;
		return t;
	endfunction

	// Present one request, hold it until taken, then log it with the model.
	// Valid stays high after acceptance so back-to-back requests never dip.
	task automatic send_request(input pfx_in_t req);
		int gap;
		gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : pick_idle();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do
			@(posedge clk);
		while (!in_ready);
		tokens_done += sb.note_token(req);
	endtask

	task automatic push_num(input logic [OPERAND_W-1:0] v);
		send_request(make_token(KIND_NUM, v, pick_opcode()));
	endtask

	task automatic apply_op(input logic [OPCODE_W-1:0] code);
		send_request(make_token(KIND_OP, $urandom(), code));
	endtask

	task automatic finish_expr();
		send_request(make_token(KIND_END, $urandom(), pick_opcode()));
	endtask

	task automatic send_spare();
		send_request(make_token(KIND_SPARE, $urandom(), pick_opcode()));
	endtask

	// Drop valid and hold off until every outstanding answer is back
	task automatic await_answers();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Well-formed expression: pushes and operators interleaved so the depth
	// never falls below two at an operator and ends at one
	task automatic run_expression(input bit noisy);
		int operands;
		int pushes_left;
		int ops_left;
		int expr_depth;
		operands    = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 16);
		pushes_left = operands;
		ops_left    = operands - 1;
		expr_depth  = 0;
		while (pushes_left > 0 || ops_left > 0) begin
			if (noisy && $urandom_range(0, 5) == 0)
				send_spare();
			if (pushes_left > 0 && (expr_depth < 2 || $urandom_range(0, 1) == 0)) begin
				push_num(pick_value());
				pushes_left--;
				expr_depth++;
			end else begin
				apply_op(pick_opcode());
				ops_left--;
				expr_depth--;
			end
		end
		finish_expr();
	endtask

	// Broken stream: arbitrary tokens of any kind, usually closed by an end
	task automatic run_garbage();
		int len;
		len = $urandom_range(1, 10);
		repeat (len)
			send_request(make_token(KIND_W'($urandom_range(0, 3)), pick_value(), pick_opcode()));
		if ($urandom_range(0, 4) != 0)
			finish_expr();
	endtask

	// Sink side: check each accepted result, then pick the next ready level
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_answer(out_data);
		if (no_idle)
			out_ready <= 1'b1;
		else if (rx_hold > 0) begin
			rx_hold = rx_hold - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 2) == 0) begin
			rx_hold = pick_idle() - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	// Watchdog: end the run if no handshake completes for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int pick;
		sb       = new();
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		no_idle  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// End on an empty stack reports leftover data
		finish_expr();
		// Largest value plus one saturates at the top
		push_num(32'h7FFF_FFFF);
		push_num(32'h0001_0000);
		apply_op(OP_ADD);
		finish_expr();
		// Smallest value minus one saturates at the bottom
		push_num(32'h8000_0000);
		push_num(32'h0001_0000);
		apply_op(OP_SUB);
		finish_expr();
		// Square of the most negative value overflows the product
		push_num(32'h8000_0000);
		push_num(32'h8000_0000);
		apply_op(OP_MUL);
		finish_expr();
		// 3.0 / -2.0 gives -1.5
		push_num(32'h0003_0000);
		push_num(32'hFFFE_0000);
		apply_op(OP_DIV);
		finish_expr();
		// Divide by zero, then tokens that must be ignored until the end
		push_num(32'h0005_0000);
		push_num(32'h0000_0000);
		apply_op(OP_DIV);
		push_num(32'h0001_0000);
		send_spare();
		finish_expr();
		// Operator with nothing on the stack
		apply_op(OP_ADD);
		finish_expr();

		// Hold the sender until the pipeline is empty
		await_answers();

		// Fill the stack, then push once more to raise overflow
		repeat (STACK_DEPTH_DEF + 1)
			push_num(pick_value());
		finish_expr();

		while (tokens_done < TOKEN_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				no_idle <= ~no_idle;
			if (pick < 4)
				await_answers();
			pick = $urandom_range(0, 99);
			if (pick < 72)
				run_expression(1'b0);
			else if (pick < 88)
				run_garbage();
			else
				run_expression(1'b1);
		end

		await_answers();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
